### hdl/fel_pkg.sv
// Shared types and constants for the failsafe event latch.
// Used by failsafe_event_latch_unit and fel_checker; depends on nothing.
`timescale 1ns / 1ps

package fel_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_GENERAL_TIMEOUT = 3'd0;
    localparam cfg_idx_t CFG_GPS_TIMEOUT     = 3'd1;
    localparam cfg_idx_t CFG_ACTION_SELECT   = 3'd2;
    localparam cfg_idx_t CFG_RTK_CHECK_EN    = 3'd3;
    localparam cfg_idx_t CFG_GPS_EVENT_MASK  = 3'd4;

    localparam int CFG_DATA_W = 32;

    // Reset values of the configuration registers
    localparam logic [31:0] GENERAL_TIMEOUT_RST = 32'd5000;
    localparam logic [31:0] GPS_TIMEOUT_RST     = 32'd5000;
    localparam logic [1:0]  ACTION_SELECT_RST   = 2'd0;
    localparam logic        RTK_CHECK_EN_RST    = 1'b0;
    localparam logic [7:0]  GPS_EVENT_MASK_RST  = 8'd8;

    // A fix this old or older breaks the RTK lock
    localparam logic [31:0] FIX_AGE_LIMIT_MS = 32'd1000;

    // Input command codes
    localparam logic CMD_SET_CLEAR = 1'b0;
    localparam logic CMD_GPS_CHECK = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  event_mask;
        logic        event_on;
        logic [31:0] now_ms;
        logic        mode_is_rtl_or_hold;
        logic [31:0] last_fix_ms;
        logic        gps0_rtk_fixed;
        logic        gps1_rtk_fixed;
    } in_item_t;

    typedef struct packed {
        logic [7:0] active_events;
        logic [7:0] triggered_events;
        logic       episode_started;
        logic       episode_ended;
        logic       fired;
        logic [1:0] action;
    } out_item_t;

endpackage

### hdl/failsafe_event_latch_unit.sv
// Failsafe event latch: event mask, latched trigger mask and episode timer.
// Depends on fel_pkg for the payload structs and register codes.
`timescale 1ns / 1ps
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------
//  in      | input     | in_valid / in_ready | in_data  (in_item_t)
//  out     | output    | out_valid/out_ready | out_data (out_item_t)
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One beat per cycle sustained while the output is not stalled; a beat passes
//  the input register, then the result register with the state update.
//  The fix age check runs as the beat is captured; the event update, episode
//  timer and fire decision run between the input and result registers.
//  Reset clears the event state and loads the register defaults; cfg_ready
//  is always high. A stalled output holds the input register, which still
//  refills in the same cycle the result is taken.

module failsafe_event_latch_unit
    import fel_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef struct packed {
        logic        cmd;
        logic [7:0]  event_mask;
        logic        event_on;
        logic [31:0] now_ms;
        logic        safe_mode;
        logic        lock_ok;
    } stage_t;

    // Configuration registers
    logic [31:0] general_timeout_reg;
    logic [31:0] gps_timeout_reg;
    logic [1:0]  action_select_reg;
    logic        rtk_check_en_reg;
    logic [7:0]  gps_event_mask_reg;

    // Event state
    logic [7:0]  active_reg,  active_next;
    logic [7:0]  trig_reg,    trig_next;
    logic [31:0] start_reg,   start_next;

    // Pipeline registers
    logic        stage_valid_reg;
    stage_t      stage_reg, stage_next;
    logic        out_valid_reg;
    out_item_t   out_reg, out_next;

    logic        advance;
    logic [31:0] fix_age;
    logic        skip;
    logic [7:0]  apply_mask;
    logic        apply_set;
    logic [7:0]  act_upd;
    logic [7:0]  trig_and;
    logic        started;
    logic        ended;
    logic [31:0] span;
    logic        fire;

    assign cfg_ready = 1'b1;
    assign advance   = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stage_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Write configuration registers; drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            general_timeout_reg <= GENERAL_TIMEOUT_RST;
            gps_timeout_reg     <= GPS_TIMEOUT_RST;
            action_select_reg   <= ACTION_SELECT_RST;
            rtk_check_en_reg    <= RTK_CHECK_EN_RST;
            gps_event_mask_reg  <= GPS_EVENT_MASK_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GENERAL_TIMEOUT: general_timeout_reg <= cfg_data;
                CFG_GPS_TIMEOUT:     gps_timeout_reg     <= cfg_data;
                CFG_ACTION_SELECT:   action_select_reg   <= cfg_data[1:0];
                CFG_RTK_CHECK_EN:    rtk_check_en_reg    <= cfg_data[0];
                CFG_GPS_EVENT_MASK:  gps_event_mask_reg  <= cfg_data[7:0];
                default:             ;
            endcase
        end
    end

    // Capture a beat and judge the GPS fix age on the way in
    always_comb
    begin
        fix_age              = in_data.now_ms - in_data.last_fix_ms;
        stage_next.cmd       = in_data.cmd;
        stage_next.event_mask = in_data.event_mask;
        stage_next.event_on  = in_data.event_on;
        stage_next.now_ms    = in_data.now_ms;
        stage_next.safe_mode = in_data.mode_is_rtl_or_hold;
        stage_next.lock_ok   = (fix_age < FIX_AGE_LIMIT_MS) &&
                               in_data.gps0_rtk_fixed && in_data.gps1_rtk_fixed;
    end

    // Event update, episode timer and fire decision
    always_comb
    begin
        skip       = (stage_reg.cmd == CMD_GPS_CHECK) && !rtk_check_en_reg;
        apply_mask = (stage_reg.cmd == CMD_GPS_CHECK) ? gps_event_mask_reg
                                                      : stage_reg.event_mask;
        apply_set  = (stage_reg.cmd == CMD_GPS_CHECK) ? !stage_reg.lock_ok
                                                      : stage_reg.event_on;
        act_upd    = apply_set ? (active_reg | apply_mask)
                               : (active_reg & ~apply_mask);
        started    = (active_reg == 8'd0) && (act_upd != 8'd0);
        ended      = (trig_reg != 8'd0) && (act_upd == 8'd0);
        trig_and   = trig_reg & act_upd;
        start_next = started ? stage_reg.now_ms : start_reg;
        span       = stage_reg.now_ms - start_next;
        fire       = (trig_and == 8'd0) && (act_upd != 8'd0) && !stage_reg.safe_mode &&
                     ((span > general_timeout_reg) ||
                      (((act_upd & gps_event_mask_reg) != 8'd0) &&
                       (span > gps_timeout_reg)));

        if (skip)
        begin
            active_next              = active_reg;
            trig_next                = trig_reg;
            out_next.active_events    = active_reg;
            out_next.triggered_events = trig_reg;
            out_next.episode_started  = 1'b0;
            out_next.episode_ended    = 1'b0;
            out_next.fired            = 1'b0;
            out_next.action           = 2'd0;
        end
        else
        begin
            active_next              = act_upd;
            trig_next                = fire ? act_upd : trig_and;
            out_next.active_events    = act_upd;
            out_next.triggered_events = fire ? act_upd : trig_and;
            out_next.episode_started  = started;
            out_next.episode_ended    = ended;
            out_next.fired            = fire;
            out_next.action           = fire ? action_select_reg : 2'd0;
        end
    end

    // Advance the control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            active_reg      <= 8'd0;
            trig_reg        <= 8'd0;
            start_reg       <= 32'd0;
        end
        else
        begin
            if (in_valid && in_ready)
                stage_valid_reg <= 1'b1;
            else if (advance)
                stage_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (advance && !skip)
            begin
                active_reg <= active_next;
                trig_reg   <= trig_next;
                start_reg  <= start_next;
            end
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            stage_reg <= stage_next;
        if (advance)
            out_reg <= out_next;
    end

endmodule

### hdl/fel_checker.sv
// Port-level checks for failsafe_event_latch_unit, attached by bind.
// Depends on fel_pkg for the payload structs.
`timescale 1ns / 1ps

module fel_checker
    import fel_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input in_item_t              in_data,
    input logic                  out_valid,
    input logic                  out_ready,
    input out_item_t             out_data,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input cfg_idx_t              cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // Latched mask is always a subset of the active mask
    a_trig_subset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.triggered_events & ~out_data.active_events) == 8'd0)
        else $error("triggered events outside active events");

    // Firing latches the whole nonempty active mask
    a_fire_latch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.fired |->
            out_data.triggered_events == out_data.active_events &&
            out_data.active_events != 8'd0 && !out_data.episode_ended)
        else $error("fire without a full latch");

    // An ended episode leaves nothing active or latched
    a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.episode_ended |->
            out_data.active_events == 8'd0 && out_data.triggered_events == 8'd0 &&
            !out_data.episode_started)
        else $error("episode ended with events left");

    // An action is only requested when firing
    a_action_fire: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.fired |-> out_data.action == 2'd0)
        else $error("action without fire");

endmodule

bind failsafe_event_latch_unit fel_checker u_fel_checker (.*);
